// ===== sv/csd_pkg.sv =====
// Shared types and constants for the command string decoder.
// Holds the command name table, the word kinds and the front-to-back queue word.
package csd_pkg;

  // Name table geometry.
  localparam int TABLE_SIZE  = 4;
  localparam int NAME_SLOTS  = 8;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 4;
  localparam int TASK_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_W-1:0]  POS_LIMIT  = 4'd15;
  localparam logic [CHAR_W-1:0] CHAR_END   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  // Command names, one character per slot, unused slots zero.
  localparam logic [CHAR_W-1:0] NAME_CHARS [TABLE_SIZE][NAME_SLOTS] = '{
    '{8'h73, 8'h65, 8'h72, 8'h76, 8'h6f, 8'h00, 8'h00, 8'h00},  // servo
    '{8'h6c, 8'h65, 8'h64, 8'h5f, 8'h6f, 8'h6e, 8'h00, 8'h00},  // led_on
    '{8'h6c, 8'h65, 8'h64, 8'h5f, 8'h6f, 8'h66, 8'h66, 8'h00},  // led_off
    '{8'h72, 8'h67, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // rgb
  };
  localparam logic [POS_W-1:0] NAME_LEN [TABLE_SIZE] = '{4'd5, 4'd6, 4'd7, 4'd3};

  // Character classes found by the front end.
  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_SPACE,
    KIND_END
  } kind_t;

  // One classified word as it travels through the queue.
  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
  } word_t;

  // Front end to queue write request.
  typedef struct packed {
    logic  push;
    word_t word;
  } push_t;

  // Queue to back end status.
  typedef struct packed {
    logic  empty;
    logic  full;
    word_t head;
  } qstat_t;

endpackage

// ===== sv/csd_front.sv =====
// Front end of the command string decoder: accepts input words and classifies them.
// Depends on csd_pkg; feeds csd_queue.
module csd_front (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char_code,
  input  csd_pkg::qstat_t        qstat,
  output csd_pkg::push_t         push_req
);
  import csd_pkg::*;

  // Accept whenever the queue has a free slot.
  assign in_ready = !qstat.full;

  // Classify the character and hand it to the queue.
  always_comb begin
    push_req.push           = in_valid && !qstat.full;
    push_req.word.char_code = in_char_code;
    if (in_char_code == CHAR_END) begin
      push_req.word.kind = KIND_END;
    end else if (in_char_code == CHAR_SPACE) begin
      push_req.word.kind = KIND_SPACE;
    end else begin
      push_req.word.kind = KIND_CHAR;
    end
  end

endmodule

// ===== sv/csd_queue.sv =====
// Short queue of classified words between the front and back ends.
// Depends on csd_pkg.
module csd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csd_pkg::push_t         push_req,
  input  logic                   pop,
  output csd_pkg::qstat_t        qstat
);
  import csd_pkg::*;

  word_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push_req.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_req.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_req.push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (push_req.push) begin
      slot_r[wr_ptr_r] <= push_req.word;
    end
  end

  // Status toward both ends.
  always_comb begin
    qstat.empty = (count_r == '0);
    qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
    qstat.head  = slot_r[rd_ptr_r];
  end

endmodule

// ===== sv/csd_back.sv =====
// Back end of the command string decoder: name matching, value folding and result register.
// Depends on csd_pkg; drains csd_queue.
module csd_back #(
  parameter int NUM_COMMANDS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csd_pkg::qstat_t        qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [1:0]             out_cmd_index,
  output logic [7:0]             out_command_value
);
  import csd_pkg::*;

  logic                   phase_r, phase_nxt;
  logic [TABLE_SIZE-1:0]  alive_r, alive_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [CHAR_W-1:0]      acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   found_r;
  logic [TASK_W-1:0]      task_r;
  logic [CHAR_W-1:0]      value_r;

  logic                   out_free;
  logic                   pop_end;
  logic [TABLE_SIZE-1:0]  keep;
  logic                   hit;
  logic [TASK_W-1:0]      hit_index;
  logic [CHAR_W-1:0]      folded;

  // A terminator waits until the result register can take it.
  assign out_free = !out_valid_r || out_ready;
  assign pop      = !qstat.empty && ((qstat.head.kind != KIND_END) || out_free);
  assign pop_end  = pop && (qstat.head.kind == KIND_END);

  // Per-entry prefix check for the current name character.
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      keep[i] = (pos_r < NAME_LEN[i]) &&
                (NAME_CHARS[i][pos_r[2:0]] == qstat.head.char_code);
    end
  end

  // Exact match at the terminator, lowest index wins.
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if ((i < NUM_COMMANDS) && alive_r[i] && (NAME_LEN[i] == pos_r) && (pos_r != '0)) begin
        hit       = 1'b1;
        hit_index = TASK_W'(i);
      end
    end
  end

  // Decimal fold: value*10 + char - '0', kept to eight bits.
  assign folded = (acc_r << 3) + (acc_r << 1) + qstat.head.char_code - CHAR_ZERO;

  // Decode state update for the word being drained.
  always_comb begin
    phase_nxt = phase_r;
    alive_nxt = alive_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    if (pop) begin
      if (qstat.head.kind == KIND_END) begin
        phase_nxt = 1'b0;
        alive_nxt = '1;
        pos_nxt   = '0;
        acc_nxt   = '0;
      end else if (phase_r) begin
        acc_nxt = folded;
      end else if (qstat.head.kind == KIND_SPACE) begin
        phase_nxt = 1'b1;
        acc_nxt   = '0;
      end else begin
        alive_nxt = alive_r & keep;
        if (pos_r < POS_LIMIT) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      alive_r <= '1;
      pos_r   <= '0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      alive_r <= alive_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Result register holds the word until it is taken.
  assign out_valid_nxt = (out_valid_r && !out_ready) || pop_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_end) begin
      found_r <= hit;
      task_r  <= hit_index;
      value_r <= phase_r ? acc_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_cmd_index     = task_r;
  assign out_command_value = value_r;

endmodule

// ===== sv/command_string_decoder.sv =====
// Command string decoder. Takes one character word per cycle and returns one result word
// (found, task index, value) when the zero terminator arrives; other characters give no
// result. A word accepted at the input is classified by the front end into a two-entry
// queue and drained from its head by the back end; a drained terminator's result is loaded
// into the result register and offered from then on. Sustained rate is one word per
// cycle, set by the back end's single decode step per word; the input stalls only when the
// queue is full, which happens when a terminator waits at the queue head behind a result
// word that has not been taken and one more word has arrived behind it.
module command_string_decoder #(
  parameter int NUM_COMMANDS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic [1:0] out_cmd_index,
  output logic [7:0] out_command_value
);
  import csd_pkg::*;

  push_t  push_req;
  qstat_t qstat;
  logic   pop;

  // Front end: accept and classify.
  csd_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .qstat        (qstat),
    .push_req     (push_req)
  );

  // Queue between the two ends.
  csd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .pop      (pop),
    .qstat    (qstat)
  );

  // Back end: match, fold and deliver.
  csd_back #(
    .NUM_COMMANDS (NUM_COMMANDS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .qstat             (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_cmd_index     (out_cmd_index),
    .out_command_value (out_command_value)
  );

endmodule

// ===== sv/csd_checker.sv =====
// Port-level checks for the command string decoder, bound to the top level.
// Depends only on the top level's ports.
module csd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_found,
  input logic [1:0] out_cmd_index,
  input logic [7:0] out_command_value
);

  // Reset leaves no result word pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_found) && $stable(out_cmd_index) &&
                                $stable(out_command_value))
    else $error("result payload changed while stalled");

  // An unmatched name reports task index zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_cmd_index == 2'd0)
    else $error("nonzero task index without a match");

  // An empty queue path means the input is never refused outside a pending result.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(out_valid) && $past(rst_n) |-> in_ready)
    else $error("input refused while no result was pending");

endmodule

bind command_string_decoder csd_checker u_csd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_cmd_index     (out_cmd_index),
  .out_command_value (out_command_value)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for command_string_decoder.
// Drives command strings word by word with random gaps on both channels and checks every
// result word against its predictor or typed expectation. Uses csd_pkg and the DUT.
module testbench;

  localparam int NUM_COMMANDS = 4;
  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 200000;

  // Task indexes as reported in out_cmd_index.
  typedef enum logic [1:0] {
    TASK_SERVO,
    TASK_LED_ON,
    TASK_LED_OFF,
    TASK_RGB
  } task_id_t;

  typedef struct packed {
    logic       found;
    task_id_t   idx;
    logic [7:0] value;
  } cmd_result_t;

  typedef struct {
    string       text;
    bit          typed;
    cmd_result_t want;
  } demo_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_found;
  logic [1:0] out_cmd_index;
  logic [7:0] out_command_value;

  command_string_decoder #(
    .NUM_COMMANDS(NUM_COMMANDS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_cmd_index    (out_cmd_index),
    .out_command_value(out_command_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Command names known to the predictor, indexed by task.
  string cmd_names [4] = '{"servo", "led_on", "led_off", "rgb"};

  // Predictor state.
  bit         in_argument;
  logic [3:0] name_alive;
  logic [3:0] name_len_seen;
  logic [7:0] argument_acc;

  cmd_result_t result_q [$];
  int          error_count;
  int          words_sent;
  int          results_seen;
  int          cycle_count;

  // The long stretch without any idling on either side.
  function automatic bit quiet_stretch();
    return words_sent >= 500 && words_sent < 800;
  endfunction

  function automatic void clear_decoder();
    in_argument   = 1'b0;
    name_alive    = 4'hf;
    name_len_seen = 4'd0;
    argument_acc  = 8'd0;
  endfunction

  // Advances the predictor by one word; returns 1 when the word yields a result.
  function automatic bit decode_char(input logic [7:0] c, output cmd_result_t res);
    res = '0;
    if (c == csd_pkg::CHAR_END) begin
      // Lowest live name whose length equals the name read so far wins.
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        if (!res.found && name_alive[i] && name_len_seen != 0 &&
            cmd_names[i].len() == name_len_seen) begin
          res.found = 1'b1;
          res.idx   = task_id_t'(i);
        end
      end
      res.value = in_argument ? argument_acc : 8'd0;
      clear_decoder();
      return 1'b1;
    end
    if (in_argument) begin
      argument_acc = argument_acc * 8'd10 + c - csd_pkg::CHAR_ZERO;
    end else if (c == csd_pkg::CHAR_SPACE) begin
      in_argument  = 1'b1;
      argument_acc = 8'd0;
    end else begin
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        if (name_len_seen >= cmd_names[i].len()) begin
          name_alive[i] = 1'b0;
        end else if (cmd_names[i][name_len_seen] != c) begin
          name_alive[i] = 1'b0;
        end
      end
      if (name_len_seen != 4'd15) begin
        name_len_seen++;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in result %0d, %s: got %0d, expected %0d",
             results_seen, what, got, want);
    error_count++;
  endtask

  // Sends one word, called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [7:0] c, input bit typed, input cmd_result_t want);
    cmd_result_t predicted;
    bit          has_result;
    while (!quiet_stretch() && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_result = decode_char(c, predicted);
    if (has_result) begin
      result_q.push_back(typed ? want : predicted);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // Sends a command string followed by its terminator.
  task automatic send_string(input logic [7:0] text [$], input bit typed,
                             input cmd_result_t want);
    foreach (text[k]) begin
      send_word(text[k], 1'b0, '0);
    end
    send_word(csd_pkg::CHAR_END, typed, want);
  endtask

  // Builds one random command string: a table name with an optional value, or random content.
  task automatic build_random_string(output logic [7:0] text [$]);
    int kind;
    int pick;
    int digits;
    int len;
    kind = $urandom_range(99);
    text = {};
    if (kind < 60) begin
      pick = $urandom_range(NUM_COMMANDS - 1);
      for (int k = 0; k < cmd_names[pick].len(); k++) begin
        text.push_back(cmd_names[pick][k]);
      end
      // Occasionally spoil the name: cut it short, extend it, or alter one letter.
      case ($urandom_range(9))
        0: void'(text.pop_back());
        1: text.push_back(8'($urandom_range(255, 1)));
        2: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255, 1));
        default: ;
      endcase
      if ($urandom_range(3) != 0) begin
        text.push_back(csd_pkg::CHAR_SPACE);
        digits = $urandom_range(4);
        for (int k = 0; k < digits; k++) begin
          if ($urandom_range(9) == 0) begin
            text.push_back(8'($urandom_range(255, 1)));
          end else begin
            text.push_back(8'(csd_pkg::CHAR_ZERO + $urandom_range(9)));
          end
        end
      end
    end else if (kind < 85) begin
      len = $urandom_range(12);
      for (int k = 0; k < len; k++) begin
        text.push_back(8'($urandom_range(255, 1)));
      end
    end else if (kind < 93) begin
      // Long names, some long enough to saturate the position counter.
      len = $urandom_range(19, 13);
      for (int k = 0; k < len; k++) begin
        text.push_back(8'($urandom_range(8'h7a, 8'h61)));
      end
    end else begin
      text.push_back(csd_pkg::CHAR_SPACE);
      digits = $urandom_range(3);
      for (int k = 0; k < digits; k++) begin
        text.push_back(8'(csd_pkg::CHAR_ZERO + $urandom_range(9)));
      end
    end
  endtask

  // Directed strings; a typed expectation is used where it is obvious.
  demo_row_t demo_rows [5] = '{
    '{"",        1'b1, '{1'b0, TASK_SERVO,  8'd0}},    // empty name right after reset
    '{"rgb 255", 1'b1, '{1'b1, TASK_RGB,    8'd255}},  // largest value
    '{"servo",   1'b1, '{1'b1, TASK_SERVO,  8'd0}},    // no space, no value
    '{"led_on",  1'b0, '{1'b0, TASK_SERVO,  8'd0}},
    '{" \377 ",  1'b0, '{1'b0, TASK_SERVO,  8'd0}}     // empty name, later space folded
  };

  // Result word checker.
  always @(posedge clk) begin
    cmd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("unexpected result word: found %0d task %0d value %0d",
                 out_found, out_cmd_index, out_command_value);
        error_count++;
      end else begin
        want = result_q.pop_front();
        if (out_found !== want.found)
          report_mismatch("found", out_found, want.found);
        if (out_cmd_index !== want.idx)
          report_mismatch("cmd_index", out_cmd_index, want.idx);
        if (out_command_value !== want.value)
          report_mismatch("command_value", out_command_value, want.value);
      end
      results_seen++;
    end
  end

  // Receiver stalls at random outside the quiet stretch.
  always @(negedge clk) begin
    out_ready <= quiet_stretch() || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] text [$];
    clear_decoder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (demo_rows[r]) begin
      text = {};
      for (int k = 0; k < demo_rows[r].text.len(); k++) begin
        text.push_back(demo_rows[r].text[k]);
      end
      send_string(text, demo_rows[r].typed, demo_rows[r].want);
    end

    while (words_sent < RANDOM_WORDS) begin
      build_random_string(text);
      send_string(text, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle.
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
